[hw/rtl/ppd_pkg.sv]
package ppd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 16;
   localparam int HEIGHT_BITS = 16;

   // widest of sample and threshold, for the height compare
   localparam int CMP_BITS = (SAMPLE_BITS > HEIGHT_BITS) ? SAMPLE_BITS : HEIGHT_BITS;

   localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [INDEX_BITS-1:0]  index_type;
   typedef logic [HEIGHT_BITS-1:0] height_type;

endpackage

[hw/rtl/ppd_req_if.sv]
interface ppd_req_if;
   import ppd_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;
   logic       record_last;

   modport source (output valid, output sample, output record_last, input ready);
   modport sink   (input valid, input sample, input record_last, output ready);
endinterface

[hw/rtl/ppd_rsp_if.sv]
interface ppd_rsp_if;
   import ppd_pkg::*;

   logic       valid;
   logic       ready;
   logic       is_peak;
   index_type  peak_index;
   sample_type peak_height;
   logic       record_end;

   modport source (output valid, output is_peak, output peak_index, output peak_height,
                   output record_end, input ready);
   modport sink   (input valid, input is_peak, input peak_index, input peak_height,
                   input record_end, output ready);
endinterface

[hw/rtl/plateau_peak_detector.sv]
// Streaming plateau peak finder. Each accepted sample is captured in an input
// register and evaluated from there against the running record state (a few
// compares and one add for the plateau midpoint); any result lands in an output
// register. Throughput is one sample per clock while no result is held up at
// the output register. A sample that gives no result never waits on the result
// side; one that does waits only while the output register still holds an
// untaken result. Results: a confirmed peak at or above min_height, and on the
// last sample of a record always one result carrying record_end (the peak it
// confirms, or an end marker with zero index and height). min_height is written
// through csr_we/csr_wdata by the user only while idle; the block does not check.
module plateau_peak_detector (
   input  logic                    clock,
   input  logic                    reset,
   ppd_req_if.sink                 req,
   ppd_rsp_if.source               rsp,
   input  logic                    csr_we,
   input  ppd_pkg::height_type     csr_wdata
);
   import ppd_pkg::*;

   height_type min_height_ff;

   // input stage
   logic       in_valid_ff;
   sample_type in_sample_ff;
   logic       in_last_ff;

   // record state
   index_type  count_ff, count_in;
   sample_type prev_ff, prev_in;
   logic       open_ff, open_in;
   index_type  left_ff, left_in;
   sample_type value_ff, value_in;

   // output register
   logic       rsp_valid_ff;
   logic       rsp_peak_ff;
   index_type  rsp_index_ff;
   sample_type rsp_height_ff;
   logic       rsp_end_ff;

   logic                  found;
   logic                  keep;
   logic                  emit;
   logic                  out_free;
   logic                  advance;
   index_type             right;
   logic [INDEX_BITS:0]   mid_sum;
   index_type             mid_index;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign advance  = in_valid_ff && (!emit || out_free);
   assign req.ready = !in_valid_ff || advance;

   assign right     = count_ff - index_type'(1);
   assign mid_sum   = {1'b0, left_ff} + {1'b0, right};
   assign mid_index = mid_sum[INDEX_BITS:1];

   always_comb begin
      found    = 1'b0;
      open_in  = open_ff;
      left_in  = left_ff;
      value_in = value_ff;
      count_in = (count_ff != INDEX_MAX) ? count_ff + index_type'(1) : count_ff;
      prev_in  = in_sample_ff;

      if (open_ff) begin
         if (in_sample_ff < value_ff) begin
            found   = 1'b1;
            open_in = 1'b0;
         end else if (in_sample_ff > value_ff) begin
            // larger sample restarts the candidate here
            open_in  = !in_last_ff;
            left_in  = count_ff;
            value_in = in_sample_ff;
         end
      end else if ((count_ff != '0) && (prev_ff < in_sample_ff) && !in_last_ff) begin
         open_in  = 1'b1;
         left_in  = count_ff;
         value_in = in_sample_ff;
      end

      if (in_last_ff) begin
         count_in = '0;
         prev_in  = '0;
         open_in  = 1'b0;
         left_in  = '0;
         value_in = '0;
      end
   end

   assign keep = found &&
                 !(CMP_BITS'(value_ff) < CMP_BITS'(min_height_ff));
   assign emit = keep || in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_height_ff <= '0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         prev_ff       <= '0;
         open_ff       <= 1'b0;
         left_ff       <= '0;
         value_ff      <= '0;
      end else begin
         if (csr_we) begin
            min_height_ff <= csr_wdata;
         end

         if (req.valid && req.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            count_ff <= count_in;
            prev_ff  <= prev_in;
            open_ff  <= open_in;
            left_ff  <= left_in;
            value_ff <= value_in;
         end

         if (advance && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_sample_ff <= req.sample;
         in_last_ff   <= req.record_last;
      end
      if (advance && emit) begin
         rsp_peak_ff   <= keep;
         rsp_index_ff  <= keep ? mid_index : '0;
         rsp_height_ff <= keep ? value_ff : '0;
         rsp_end_ff    <= in_last_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.is_peak     = rsp_peak_ff;
   assign rsp.peak_index  = rsp_index_ff;
   assign rsp.peak_height = rsp_height_ff;
   assign rsp.record_end  = rsp_end_ff;

endmodule

[tb/ppd_peak_tracker_pkg.sv]
`timescale 1ns / 100ps

package ppd_peak_tracker_pkg;
   import ppd_pkg::*;

   typedef struct packed {
      logic       is_peak;
      index_type  peak_index;
      sample_type peak_height;
      logic       record_end;
   } peak_report_type;

   class peak_tracker;
      height_type      min_height    = '0;
      index_type       sample_count  = '0;
      sample_type      prev_sample   = '0;
      bit              plateau_open  = 1'b0;
      index_type       plateau_left  = '0;
      sample_type      plateau_value = '0;
      peak_report_type expected_reports[$];
      int unsigned     failures      = 0;

      function int unsigned pending();
         return expected_reports.size();
      endfunction

      // work out the report, if any, that one accepted sample transaction causes
      function void note_sample(sample_type x, logic last);
         index_type           idx;
         index_type           right;
         logic [INDEX_BITS:0] mid_sum;
         peak_report_type     rep;
         idx = sample_count;
         rep = '0;
         if (plateau_open) begin
            if (x < plateau_value) begin
               right = idx - 1'b1;
               mid_sum = {1'b0, plateau_left} + {1'b0, right};
               rep.is_peak = (plateau_value >= min_height);
               rep.peak_index = mid_sum[INDEX_BITS:1];
               rep.peak_height = plateau_value;
               plateau_open = 1'b0;
            end else if (x > plateau_value) begin
               // a higher sample restarts the candidate unless the record ends here
               plateau_open = !last;
               plateau_left = idx;
               plateau_value = x;
            end
         end else if (idx != '0 && prev_sample < x && !last) begin
            plateau_open = 1'b1;
            plateau_left = idx;
            plateau_value = x;
         end
         prev_sample = x;
         if (sample_count != INDEX_MAX) begin
            sample_count = sample_count + 1'b1;
         end
         if (last) begin
            sample_count = '0;
            prev_sample = '0;
            plateau_open = 1'b0;
            plateau_left = '0;
            plateau_value = '0;
         end
         if (!rep.is_peak) begin
            rep.peak_index = '0;
            rep.peak_height = '0;
         end
         rep.record_end = last;
         if (rep.is_peak || last) begin
            expected_reports.push_back(rep);
         end
      endfunction

      function void check_report(peak_report_type got);
         peak_report_type want;
         if (expected_reports.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("unexpected result: is_peak=%0b index=%0d height=%0d end=%0b",
                        got.is_peak, got.peak_index, got.peak_height, got.record_end);
            end
            return;
         end
         want = expected_reports.pop_front();
         if (got.is_peak !== want.is_peak || got.peak_index !== want.peak_index ||
             got.peak_height !== want.peak_height || got.record_end !== want.record_end) begin
            failures++;
            if (failures <= 10) begin
               $display("result mismatch: expected is_peak=%0b index=%0d height=%0d end=%0b",
                        want.is_peak, want.peak_index, want.peak_height, want.record_end);
               $display("                 actual   is_peak=%0b index=%0d height=%0d end=%0b",
                        got.is_peak, got.peak_index, got.peak_height, got.record_end);
            end
         end
      endfunction
   endclass

endpackage

[tb/plateau_peak_detector_tb.sv]
`timescale 1ns / 100ps

module plateau_peak_detector_tb;
   import ppd_pkg::*;
   import ppd_peak_tracker_pkg::*;

   localparam int IDLE_MAX        = 18;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 4;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RANDOM_ITEMS    = 1700;
   localparam int PHASES          = 8;
   localparam int DIRECTED_ITEMS  = 25;

   logic       clock;
   logic       reset;
   logic       csr_we;
   height_type csr_wdata;

   ppd_req_if req ();
   ppd_rsp_if rsp ();

   plateau_peak_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   peak_tracker tracker;

   bit req_idle_en  = 1'b1;
   bit rsp_idle_en  = 1'b1;
   bit rsp_hold_req = 1'b0;

   int unsigned cycle_count = 0;

   // one sample per record line: single sample, two samples, peak confirmed by the last,
   // wide plateau then a plateau running to the end, first sample high,
   // restart on a higher sample, full-scale plateau
   sample_type directed_samples [DIRECTED_ITEMS] = '{
      16'hFFFF,
      16'd0, 16'hFFFF,
      16'd0, 16'd5, 16'd3,
      16'd1, 16'd7, 16'd7, 16'd7, 16'd2, 16'd9, 16'd9,
      16'd9, 16'd3, 16'd3,
      16'd0, 16'd4, 16'd8, 16'd2,
      16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0
   };
   bit directed_last [DIRECTED_ITEMS] = '{
      1'b1,
      1'b0, 1'b1,
      1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         tracker.note_sample(req.sample, req.record_last);
      end
      if (!reset && rsp.valid && rsp.ready) begin
         tracker.check_report(peak_report_type'({rsp.is_peak, rsp.peak_index,
                                                 rsp.peak_height, rsp.record_end}));
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned stall;
      rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            stall = RSP_HOLD_CYCLES;
         end else begin
            stall = rsp_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
         end
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!(rsp.valid && rsp.ready));
      end
   end

   task automatic send_sample(sample_type value, bit last);
      int unsigned gap;
      gap = req_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.sample      <= value;
      req.record_last <= last;
      do @(posedge clock); while (!(req.valid && req.ready));
   endtask

   // stop offering, wait for every expected result, then let the pipe empty
   task automatic drain();
      req.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_height(height_type value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.min_height = value;
   endtask

   // shaped records walk up and down with held levels so plateaus form
   task automatic send_record(int unsigned len, bit shaped);
      sample_type  value;
      int unsigned pick;
      value = sample_type'($urandom);
      for (int unsigned i = 0; i < len; i++) begin
         if (shaped) begin
            pick = $urandom_range(0, 9);
            if (pick >= 3) begin
               if (pick < 6) begin
                  value = value + sample_type'($urandom_range(1, 300));
               end else if (pick < 9) begin
                  value = value - sample_type'($urandom_range(1, 300));
               end else begin
                  value = sample_type'($urandom);
               end
            end
         end else begin
            value = sample_type'($urandom);
         end
         send_sample(value, i == len - 1);
      end
   endtask

   initial begin
      int unsigned sent;
      int unsigned len;
      int unsigned pick;
      height_type  threshold;

      tracker = new();
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_wdata       <= '0;
      req.valid       <= 1'b0;
      req.sample      <= '0;
      req.record_last <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ITEMS; i++) begin
         send_sample(directed_samples[i], directed_last[i]);
      end

      sent = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            threshold = '1;
         end else if (phase == 1) begin
            threshold = '0;
         end else if (phase == 2) begin
            threshold = height_type'($urandom_range(0, 2000));
         end else begin
            threshold = height_type'($urandom);
         end
         write_min_height(threshold);

         if (phase == 3) begin
            // sink holds off while short records keep coming, so the input backs up
            req_idle_en  = 1'b0;
            rsp_hold_req = 1'b1;
            for (int r = 0; r < 40; r++) begin
               len = $urandom_range(1, 3);
               send_record(len, 1'b1);
               sent += len;
            end
         end

         while (sent < RANDOM_ITEMS * (phase + 1) / PHASES) begin
            req_idle_en = $urandom_range(0, 3) != 0;
            rsp_idle_en = $urandom_range(0, 3) != 0;
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
               len = $urandom_range(1, 2);
            end else if (pick < 18) begin
               len = $urandom_range(3, 24);
            end else begin
               len = $urandom_range(25, 120);
            end
            send_record(len, $urandom_range(0, 9) != 0);
            sent += len;
         end
      end

      drain();
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
